/* rtl/pip_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the point-in-polygon crossing test.
// No dependencies; pip_ifs, pip_edge, pip_seq and the top level use this package.
package pip_pkg;

    // Item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // Fixed field widths
    localparam int VCOUNT_W   = 7;
    localparam int VINDEX_W   = 6;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LOAD,
        S_MULA,
        S_MULB,
        S_CMP,
        S_DONE
    } t_state;

    // Sequencer to edge unit controls
    typedef struct packed {
        logic clr;    // latch test point, clear parity
        logic load;   // shift vertex pair, load new relative vertex
        logic mul_a;  // form x1*y2
        logic mul_b;  // form x2*y1
        logic cmp;    // evaluate crossing, update parity
    } t_edge_ctl;

endpackage

/* rtl/pip_ifs.sv */
`timescale 1ns / 1ps
// Handshake channel interfaces: test/write requests, results, configuration.
// Depends on pip_pkg for the fixed field widths.
interface pip_pt_if #(parameter int COORD_BITS = 16);
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [pip_pkg::VINDEX_W-1:0]      vertex_index;
    logic signed [COORD_BITS-1:0]      coord_x;
    logic signed [COORD_BITS-1:0]      coord_y;

    modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

interface pip_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pip_pkg::VCOUNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

/* rtl/pip_vtx_mem.sv */
`timescale 1ns / 1ps
// Vertex table: one write port, one registered read port, x and y packed.
// No package dependencies.
module pip_vtx_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 16
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [W-1:0] i_wx,
    input  logic signed [W-1:0] i_wy,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [W-1:0] o_rx,
    output logic signed [W-1:0] o_ry
);
    logic [2*W-1:0] r_mem [DEPTH];
    logic [2*W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wx, i_wy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_raddr];
    end

    assign o_rx = r_rd[2*W-1:W];
    assign o_ry = r_rd[W-1:0];
endmodule

/* rtl/pip_edge.sv */
`timescale 1ns / 1ps
// Edge unit: relative vertex registers, one shared signed multiplier,
// determinant sign test and crossing parity. Depends on pip_pkg.
module pip_edge #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pip_pkg::t_edge_ctl           i_ctl,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_vx,
    input  logic signed [COORD_BITS-1:0] i_vy,
    output logic                         o_parity
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic signed [DW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [DW-1:0] dx, dy, op_a, op_b;
    logic signed [PW-1:0] prod, r_pa, r_pb;
    logic signed [SW-1:0] det;
    logic up1, up2, edge_hit;
    logic r_par;

    assign dx = DW'(i_vx) - DW'(r_px);
    assign dy = DW'(i_vy) - DW'(r_py);

    // shared multiplier: x1*y2 first, then x2*y1
    assign op_a = i_ctl.mul_a ? r_x1 : r_x2;
    assign op_b = i_ctl.mul_a ? r_y2 : r_y1;
    assign prod = op_a * op_b;

    assign det      = SW'(r_pa) - SW'(r_pb);
    assign up1      = !r_y1[DW-1] && (r_y1 != '0);
    assign up2      = !r_y2[DW-1] && (r_y2 != '0);
    assign edge_hit = (up1 != up2) && (det != '0) && (up2 ? !det[SW-1] : det[SW-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        if (i_ctl.load) begin
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_x1 <= dx;
            r_y1 <= dy;
        end
        if (i_ctl.mul_a) begin
            r_pa <= prod;
        end
        if (i_ctl.mul_b) begin
            r_pb <= prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par <= 1'b0;
        end else if (i_ctl.clr) begin
            r_par <= 1'b0;
        end else if (i_ctl.cmp && edge_hit) begin
            r_par <= ~r_par;
        end
    end

    assign o_parity = r_par;
endmodule

/* rtl/pip_seq.sv */
`timescale 1ns / 1ps
// Sequencer: vertex count register, edge walk, read addressing and the
// result output register. Depends on pip_pkg.
module pip_seq #(
    parameter int MAX_VERTICES = 64,
    parameter int AW           = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_test,
    input  logic                         i_cfg_we,
    input  logic [pip_pkg::VCOUNT_W-1:0] i_cfg_count,
    input  logic                         i_parity,
    input  logic                         i_res_ready,
    output logic                         o_idle,
    output pip_pkg::t_edge_ctl           o_ctl,
    output logic [AW-1:0]                o_rd_addr,
    output logic                         o_res_valid,
    output logic                         o_inside_res
);
    import pip_pkg::*;

    localparam int CW = VCOUNT_W;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, r_n, r_edge, sat_n;
    logic [CW:0]   rd_idx, edge_p2;
    logic          last_edge, out_free;
    logic          r_valid, r_res;

    assign sat_n     = (int'(r_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : r_count;
    assign last_edge = ({1'b0, r_edge} + (CW+1)'(1)) == {1'b0, r_n};
    assign edge_p2   = {1'b0, r_edge} + (CW+1)'(2);
    assign out_free  = !r_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        rd_idx  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_test) begin
                    o_ctl.clr = 1'b1;
                    n_state   = (sat_n == '0) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: begin
                o_ctl.load = 1'b1;
                rd_idx     = ((CW+1)'(1) < {1'b0, r_n}) ? (CW+1)'(1) : '0;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_ctl.load = 1'b1;
                n_state    = S_MULA;
            end
            S_MULA: begin
                o_ctl.mul_a = 1'b1;
                n_state     = S_MULB;
            end
            S_MULB: begin
                o_ctl.mul_b = 1'b1;
                // prefetch the far end of the next edge
                rd_idx      = (edge_p2 < {1'b0, r_n}) ? edge_p2 : '0;
                n_state     = S_CMP;
            end
            S_CMP: begin
                o_ctl.cmp = 1'b1;
                if (last_edge) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.load = 1'b1;
                    n_state    = S_MULA;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= VCOUNT_RST;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_edge <= '0;
        end else if (o_ctl.clr) begin
            r_n    <= sat_n;
            r_edge <= '0;
        end else if (o_ctl.cmp) begin
            r_edge <= r_edge + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_res <= i_parity;
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_rd_addr    = AW'(rd_idx);
    assign o_res_valid  = r_valid;
    assign o_inside_res = r_res;
endmodule

/* rtl/point_in_polygon_test_top.sv */
`timescale 1ns / 1ps
// Point-in-polygon crossing-number test, top level.
// Depends on pip_pkg, pip_ifs, pip_vtx_mem, pip_edge and pip_seq.
//
// Usage
//   i_pt carries requests. command CMD_WRITE stores (coord_x, coord_y) at
//   vertex_index and gives no result; slots at or above MAX_VERTICES are
//   dropped. command CMD_TEST walks the closed polygon of n vertices
//   (n = vertex_count, held to MAX_VERTICES) around the point and returns
//   inside_res = 1 on o_res when the crossing count is odd.
//   i_cfg writes vertex_count; it is always ready, write it only while idle.
// Request handling
//   A write leaves i_pt ready. A test holds i_pt.ready low until its result
//   is in the output register. Each edge forms x1*y2, then x2*y1, on the one
//   shared multiplier, then runs the determinant sign test, with the next
//   vertex read from the single table read port meanwhile.
// Reset
//   Synchronous, active low: sequencer idle, no result pending, vertex_count
//   back to 3. The vertex table is not cleared; test only written vertices.
// Stalls
//   A pending result waits in the output register; writes keep flowing. A
//   test that finishes while the previous result is still held waits in
//   place until that result is taken.
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pip_pt_if.sink        i_pt,
    pip_res_if.source     o_res,
    pip_cfg_if.sink       i_cfg
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    logic                         pt_accept, wr_req, test_req;
    logic                         seq_idle, parity;
    t_edge_ctl                    edge_ctl;
    logic [AW-1:0]                rd_addr;
    logic signed [COORD_BITS-1:0] pt_x, pt_y, vx, vy;

    assign pt_x      = i_pt.coord_x;
    assign pt_y      = i_pt.coord_y;
    assign pt_accept = i_pt.valid && i_pt.ready;
    // drop writes beyond the table
    assign wr_req    = pt_accept && (i_pt.command == CMD_WRITE)
                       && (int'(i_pt.vertex_index) < MAX_VERTICES);
    assign test_req  = pt_accept && (i_pt.command == CMD_TEST);

    assign i_pt.ready  = seq_idle;
    assign i_cfg.ready = 1'b1;

    pip_vtx_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .W     (COORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_req),
        .i_waddr (AW'(i_pt.vertex_index)),
        .i_wx    (pt_x),
        .i_wy    (pt_y),
        .i_raddr (rd_addr),
        .o_rx    (vx),
        .o_ry    (vy)
    );

    pip_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (edge_ctl),
        .i_px     (pt_x),
        .i_py     (pt_y),
        .i_vx     (vx),
        .i_vy     (vy),
        .o_parity (parity)
    );

    pip_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_test       (test_req),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_count  (i_cfg.vertex_count),
        .i_parity     (parity),
        .i_res_ready  (o_res.ready),
        .o_idle       (seq_idle),
        .o_ctl        (edge_ctl),
        .o_rd_addr    (rd_addr),
        .o_res_valid  (o_res.valid),
        .o_inside_res (o_res.inside_res)
    );

`ifndef SYNTH
    // a test request blocks further requests in the next cycle
    a_test_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        test_req |=> !i_pt.ready)
        else $error("request channel still ready after a test request");

    // a vertex write never blocks the request channel
    a_write_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req |=> i_pt.ready)
        else $error("request channel blocked after a vertex write");

    // a new result appears only at the end of a busy test
    a_res_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(!i_pt.ready))
        else $error("result raised without a test in progress");
`endif
endmodule
